>>> src/tcw_pkg.sv
package tcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int FILL_W = $clog2(COLS + 1);
  localparam int PHYS_W = $clog2(ROWS);

  localparam logic [7:0] NEWLINE  = 8'd10;
  localparam logic       ACT_PUT  = 1'b0;
  localparam logic       ACT_READ = 1'b1;

  typedef struct packed {
    logic             action;
    logic [7:0]       char_byte;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             scrolled;
  } result_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] chr;
  } cell_t;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic             scroll;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    cell_t            data;
  } scr_req_t;

endpackage

>>> src/tcw_screen.sv
module tcw_screen (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::scr_req_t req,
  output tcw_pkg::cell_t    rd_cell,
  output logic              rd_ok
);
  import tcw_pkg::*;

  // ring of rows: top is the physical row shown as row 0
  logic [PHYS_W-1:0] top;
  logic [FILL_W-1:0] fill [ROWS];
  cell_t             mem [CELLS];

  logic              row_ok;
  logic              col_ok;
  logic [ROW_W:0]    sum;
  logic [PHYS_W-1:0] phys;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] addr;
  logic              hit;

  always_comb begin
    row_ok = req.row < ROW_W'(ROWS);
    col_ok = req.col < COL_W'(COLS);
    sum    = (ROW_W + 1)'(req.row) + (ROW_W + 1)'(top);
    if (!row_ok) begin
      phys = '0;
    end else if (sum >= (ROW_W + 1)'(ROWS)) begin
      phys = PHYS_W'(sum - (ROW_W + 1)'(ROWS));
    end else begin
      phys = PHYS_W'(sum);
    end
    col  = col_ok ? req.col : '0;
    addr = ADDR_W'(phys) * ADDR_W'(COLS) + ADDR_W'(col);
    // cells at or past the fill mark of a row were cleared
    hit  = row_ok && col_ok && (FILL_W'(req.col) < fill[phys]);
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= req.data;
    end
    if (req.rd) begin
      rd_cell <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      rd_ok <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (req.rd) begin
        rd_ok <= hit;
      end
      if (req.wr) begin
        fill[phys] <= FILL_W'(req.col) + FILL_W'(1);
      end
      if (req.scroll) begin
        fill[top] <= '0;
        top       <= (top == PHYS_W'(ROWS - 1)) ? '0 : top + PHYS_W'(1);
      end
    end
  end

endmodule

>>> src/text_console_writer_unit.sv
// Text console of 25 rows by 80 columns with a write cursor. One word per cycle is
// taken on the item channel while item_stall is low; its result word leaves through
// one registered read of the screen memory and one output register. A put
// writes at most one screen cell; a scroll only moves the ring's top-row pointer
// and zeroes that row's fill mark, so it never stalls the item channel. The screen reads as
// all zero right after reset, with no clearing pass. text_color is written through
// the cfg channel, which is always ready.
module text_console_writer_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tcw_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tcw_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);
  import tcw_pkg::*;

  logic [7:0]       text_color;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row_next;
  logic [COL_W-1:0] cursor_col_next;

  logic             p1_valid;
  logic             p1_rd;
  logic             p1_scrolled;
  logic [ROW_W-1:0] p1_row;
  logic [COL_W-1:0] p1_col;
  logic             p1_move;

  logic             accept;
  logic             is_put;
  logic             is_nl;
  logic [COL_W-1:0] col_inc;
  logic             adv;
  logic             scroll;

  scr_req_t         req;
  cell_t            rd_cell;
  logic             rd_ok;

  assign cfg_ready  = 1'b1;
  assign p1_move    = p1_valid && (!result_valid || !result_stall);
  assign item_stall = p1_valid && !p1_move;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    is_put  = item.action == ACT_PUT;
    is_nl   = item.char_byte == NEWLINE;
    col_inc = cursor_col + COL_W'(1);
    adv     = is_nl || (col_inc == COL_W'(COLS));
    scroll  = is_put && adv && (cursor_row == ROW_W'(ROWS - 1));
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    if (is_put) begin
      cursor_col_next = adv ? '0 : col_inc;
      if (adv && !scroll) begin
        cursor_row_next = cursor_row + ROW_W'(1);
      end
    end
    req.wr       = accept && is_put && !is_nl;
    req.rd       = accept && !is_put;
    req.scroll   = accept && scroll;
    req.row      = is_put ? cursor_row : item.read_row;
    req.col      = is_put ? cursor_col : item.read_col;
    req.data     = '{color: text_color, chr: item.char_byte};
  end

  tcw_screen u_screen (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_cell (rd_cell),
    .rd_ok   (rd_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color   <= '0;
      cursor_row   <= '0;
      cursor_col   <= '0;
      p1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        text_color <= cfg_data;
      end
      if (accept) begin
        cursor_row <= cursor_row_next;
        cursor_col <= cursor_col_next;
      end
      if (accept) begin
        p1_valid <= 1'b1;
      end else if (p1_move) begin
        p1_valid <= 1'b0;
      end
      if (p1_move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_rd       <= !is_put;
      p1_scrolled <= scroll;
      p1_row      <= cursor_row_next;
      p1_col      <= cursor_col_next;
    end
    if (p1_move) begin
      result.cell_char  <= (p1_rd && rd_ok) ? rd_cell.chr : '0;
      result.cell_color <= (p1_rd && rd_ok) ? rd_cell.color : '0;
      result.cursor_row <= p1_row;
      result.cursor_col <= p1_col;
      result.scrolled   <= p1_scrolled;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor_row < ROW_W'(ROWS)) && (cursor_col < COL_W'(COLS)))
    else $error("cursor outside screen");

  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.scrolled |->
      (result.cursor_row == ROW_W'(ROWS - 1)) && (result.cursor_col == '0))
    else $error("scroll left cursor off bottom row start");

  a_scroll_put: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.scrolled |->
      (result.cell_char == '0) && (result.cell_color == '0))
    else $error("scroll reported with cell data");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    p1_valid && !p1_move |=> p1_valid && $stable(p1_row) && $stable(p1_col))
    else $error("stage lost while stalled");

endmodule
